// ----- hdl/mtte_pkg.sv -----
// Shared constants, letter table and helper functions for the multi-tap text entry block.
package mtte_pkg;

  // Display geometry and keypad letter options
  localparam int DISPLAY_COLS = 16;
  localparam int DISPLAY_ROWS = 2;
  localparam int TAP_OPTIONS  = 5;

  localparam int KEY_COUNT    = 16;
  localparam int PERIOD_W     = 16;
  localparam int CHAR_W       = 7;
  localparam int TAP_W        = 3;
  localparam int COL_W        = 4;
  localparam int ROW_W        = 1;
  localparam int KEY_W        = 4;
  localparam int DIV_CNT_W    = 4;

  localparam logic [PERIOD_W-1:0] FORGET_PERIOD_RESET = 16'd50000;
  localparam logic [COL_W-1:0]    LAST_COL = COL_W'(DISPLAY_COLS - 1);
  localparam logic [ROW_W-1:0]    LAST_ROW = ROW_W'(DISPLAY_ROWS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(PERIOD_W - 1);
  localparam logic [TAP_W-1:0]    MAX_TAP = TAP_W'(TAP_OPTIONS - 1);

  // Item opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [CHAR_W-1:0] char_t;

  // Letters carried by each key (row * 4 + column); zero ends the list
  localparam char_t LETTERS [KEY_COUNT][TAP_OPTIONS] = '{
    '{7'h31, 7'h00, 7'h00, 7'h00, 7'h00},  // 1
    '{7'h32, 7'h61, 7'h62, 7'h63, 7'h00},  // 2 a b c
    '{7'h33, 7'h64, 7'h65, 7'h66, 7'h00},  // 3 d e f
    '{7'h55, 7'h00, 7'h00, 7'h00, 7'h00},  // U
    '{7'h34, 7'h67, 7'h68, 7'h69, 7'h00},  // 4 g h i
    '{7'h35, 7'h6a, 7'h6b, 7'h6c, 7'h00},  // 5 j k l
    '{7'h36, 7'h6d, 7'h6e, 7'h6f, 7'h00},  // 6 m n o
    '{7'h44, 7'h00, 7'h00, 7'h00, 7'h00},  // D
    '{7'h37, 7'h70, 7'h71, 7'h72, 7'h73},  // 7 p q r s
    '{7'h38, 7'h74, 7'h75, 7'h76, 7'h00},  // 8 t u v
    '{7'h39, 7'h77, 7'h78, 7'h79, 7'h7a},  // 9 w x y z
    '{7'h4d, 7'h00, 7'h00, 7'h00, 7'h00},  // M
    '{7'h4e, 7'h00, 7'h00, 7'h00, 7'h00},  // N
    '{7'h30, 7'h00, 7'h00, 7'h00, 7'h00},  // 0
    '{7'h53, 7'h00, 7'h00, 7'h00, 7'h00},  // S
    '{7'h45, 7'h00, 7'h00, 7'h00, 7'h00}   // E
  };

  // Number of letters on a key: leading non-zero entries, at least one
  function automatic logic [TAP_W-1:0] letter_count(input logic [KEY_W-1:0] key);
    logic [TAP_W-1:0] n;
    logic             stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < TAP_OPTIONS; i++) begin
      if (!stop && LETTERS[key][i] != '0) begin
        n = n + TAP_W'(1);
      end else begin
        stop = 1'b1;
      end
    end
    if (n == '0) begin
      n = TAP_W'(1);
    end
    return n;
  endfunction

  // Letter at a tap position; positions past the table read the first letter
  function automatic char_t letter_at(input logic [KEY_W-1:0] key,
                                      input logic [TAP_W-1:0] idx);
    char_t c;
    c = LETTERS[key][0];
    for (int i = 0; i < TAP_OPTIONS; i++) begin
      if (idx == TAP_W'(i)) begin
        c = LETTERS[key][i];
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/mtte_ifs.sv -----
// Handshake channel interfaces: key/tick input, display write output, period config.
interface mtte_in_if;
  import mtte_pkg::*;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] key_row;
  logic [1:0] key_col;
  modport source (output valid, output op, output key_row, output key_col, input ready);
  modport sink   (input valid, input op, input key_row, input key_col, output ready);
endinterface

interface mtte_out_if;
  import mtte_pkg::*;
  logic             valid;
  logic             ready;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  cell_row;
  logic [COL_W-1:0]  cell_col;
  logic              replaced;
  logic [TAP_W-1:0]  tap_index;
  modport source (output valid, output char_code, output cell_row, output cell_col,
                  output replaced, output tap_index, input ready);
  modport sink   (input valid, input char_code, input cell_row, input cell_col,
                  input replaced, input tap_index, output ready);
endinterface

interface mtte_cfg_if;
  import mtte_pkg::*;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/multi_tap_text_entry.sv -----
// Multi-tap keypad text entry: key/tick items in, display cell writes out.
//
// Channels: key_in takes one item per valid/ready edge, either a key press
// (row, column) or a bare timer tick. cell_out gives one cell write per key
// press and nothing per tick. cfg writes forget_period (0 acts as 1).
// Path: an accepted item waits in the input register, then its cell write
// is loaded into the result register, which drives cell_out.
// Throughput: one item per cycle while cell_out is taken and no period
// reduction runs; the input and output registers let a new item in while
// a result waits. A period write starts a bit-serial remainder unit that
// reduces the tick counter against the new period; key_in and cfg are held
// not ready while it runs.
// Reset: cursor at row 0 column 0, tick counter 0, no previous key, period
// 50000; no result pending.
// Receiver stall: the result register holds; a key item in the input
// register waits for it, ticks pass on, and key_in drops ready once the
// input register is blocked.
module multi_tap_text_entry (
  input  logic      clk,
  input  logic      rst,
  mtte_in_if.sink   key_in,
  mtte_out_if.source cell_out,
  mtte_cfg_if.sink  cfg
);
  import mtte_pkg::*;

  // Configuration and tick counter
  logic [PERIOD_W-1:0] forget_period;
  logic [PERIOD_W-1:0] tick_count;
  logic [PERIOD_W-1:0] period_eff;

  // Remainder unit
  logic                 busy;
  logic [DIV_CNT_W-1:0] div_step;
  logic [PERIOD_W-1:0]  div_rem;
  logic [PERIOD_W-1:0]  div_src;
  logic [PERIOD_W:0]    div_shift;
  logic [PERIOD_W-1:0]  div_rem_next;

  // Input register
  logic       s1_valid;
  logic       s1_op;
  logic [KEY_W-1:0] s1_key;
  logic       s1_advance;
  logic       out_free;

  // Running state
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic             last_key_valid;
  logic [KEY_W-1:0] last_key;
  logic [TAP_W-1:0] tap_count;

  // Per-item logic
  logic              over;
  logic [PERIOD_W-1:0] tick_cur;
  logic [PERIOD_W:0] tick_sum;
  logic              tick_wrap;
  logic [PERIOD_W-1:0] tick_count_next;
  logic              key_known;
  logic              repeat_tap;
  logic [TAP_W-1:0]  count;
  logic [TAP_W-1:0]  tap_count_next;
  logic [COL_W-1:0]  wr_col;
  logic [ROW_W-1:0]  wr_row;
  logic [COL_W-1:0]  cursor_col_next;
  logic [ROW_W-1:0]  cursor_row_next;

  assign period_eff = (forget_period == '0) ? PERIOD_W'(1) : forget_period;

  // Handshakes
  assign out_free     = !cell_out.valid || cell_out.ready;
  assign s1_advance   = s1_valid && !busy && (s1_op == OP_TICK || out_free);
  assign key_in.ready = !busy && (!s1_valid || s1_advance);
  assign cfg.ready    = !busy && !s1_valid;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      forget_period <= FORGET_PERIOD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      forget_period <= cfg.data;
    end
  end

  // Restoring remainder step: tick_count mod period, one bit a cycle
  always_comb begin
    div_shift = {div_rem, div_src[PERIOD_W-1]};
    if (div_shift >= {1'b0, period_eff}) begin
      div_rem_next = PERIOD_W'(div_shift - {1'b0, period_eff});
    end else begin
      div_rem_next = div_shift[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      div_step <= '0;
    end else if (cfg.valid && cfg.ready) begin
      busy     <= 1'b1;
      div_step <= '0;
    end else if (busy) begin
      div_step <= div_step + DIV_CNT_W'(1);
      if (div_step == DIV_LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg.valid && cfg.ready) begin
      div_rem <= '0;
      div_src <= tick_count;
    end else if (busy) begin
      div_rem <= div_rem_next;
      div_src <= {div_src[PERIOD_W-2:0], 1'b0};
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_in.ready) begin
      s1_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready) begin
      s1_op  <= key_in.op;
      s1_key <= {key_in.key_row, key_in.key_col};
    end
  end

  // Tick counter: a count at or above a new period uses its reduced value
  always_comb begin
    over            = tick_count >= period_eff;
    tick_cur        = over ? div_rem : tick_count;
    tick_sum        = {1'b0, tick_cur} + (PERIOD_W+1)'(1);
    tick_wrap       = over || (tick_sum >= {1'b0, period_eff});
    tick_count_next = (tick_sum >= {1'b0, period_eff}) ? '0 : tick_sum[PERIOD_W-1:0];
  end

  // Tap selection and cursor movement
  always_comb begin
    key_known  = last_key_valid && !tick_wrap;
    repeat_tap = key_known && (last_key == s1_key);
    count      = letter_count(s1_key);
    if (repeat_tap) begin
      tap_count_next = (tap_count + TAP_W'(1) >= count) ? '0 : tap_count + TAP_W'(1);
    end else begin
      tap_count_next = '0;
    end

    // A repeated tap rewrites the cell before the cursor; the cursor stays
    if (repeat_tap) begin
      if (cursor_col == '0) begin
        wr_col = LAST_COL;
        wr_row = (cursor_row == '0) ? LAST_ROW : cursor_row - ROW_W'(1);
      end else begin
        wr_col = cursor_col - COL_W'(1);
        wr_row = cursor_row;
      end
      cursor_col_next = cursor_col;
      cursor_row_next = cursor_row;
    end else begin
      wr_col = cursor_col;
      wr_row = cursor_row;
      if (cursor_col == LAST_COL) begin
        cursor_col_next = '0;
        cursor_row_next = (cursor_row == LAST_ROW) ? '0 : cursor_row + ROW_W'(1);
      end else begin
        cursor_col_next = cursor_col + COL_W'(1);
        cursor_row_next = cursor_row;
      end
    end
  end

  // Running state update
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      cursor_col     <= '0;
      cursor_row     <= '0;
      last_key_valid <= 1'b0;
      last_key       <= '0;
      tap_count      <= '0;
    end else if (s1_advance) begin
      tick_count <= tick_count_next;
      if (s1_op == OP_KEY) begin
        cursor_col     <= cursor_col_next;
        cursor_row     <= cursor_row_next;
        last_key_valid <= 1'b1;
        last_key       <= s1_key;
        tap_count      <= tap_count_next;
      end else if (tick_wrap) begin
        last_key_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (s1_advance && s1_op == OP_KEY) begin
      cell_out.valid <= 1'b1;
    end else if (cell_out.ready) begin
      cell_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_op == OP_KEY) begin
      cell_out.char_code <= letter_at(s1_key, tap_count_next);
      cell_out.cell_row  <= wr_row;
      cell_out.cell_col  <= wr_col;
      cell_out.replaced  <= repeat_tap;
      cell_out.tap_index <= tap_count_next;
    end
  end

endmodule

// ----- hdl/mtte_checker.sv -----
// Port-level checks for the multi-tap text entry block, bound to the top level.
module mtte_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [6:0] char_code,
  input logic [0:0] cell_row,
  input logic [3:0] cell_col,
  input logic       replaced,
  input logic [2:0] tap_index,
  input logic       cfg_valid,
  input logic       cfg_ready
);
  import mtte_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(cell_row)
      && $stable(cell_col) && $stable(replaced) && $stable(tap_index))
    else $error("stalled result changed");

  // A period write blocks key items while the counter is reduced
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready && !cfg_ready)
    else $error("input taken right after a period write");

  // Tap index stays within the letter options
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tap_index <= MAX_TAP)
    else $error("tap index out of range");

  // A fresh key always starts at its first letter
  a_fresh_tap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !replaced |-> tap_index == '0)
    else $error("new key not at first letter");

  // Nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_tap_text_entry mtte_checker u_mtte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (key_in.ready),
  .out_valid (cell_out.valid),
  .out_ready (cell_out.ready),
  .char_code (cell_out.char_code),
  .cell_row  (cell_out.cell_row),
  .cell_col  (cell_out.cell_col),
  .replaced  (cell_out.replaced),
  .tap_index (cell_out.tap_index),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready)
);

// ----- verif/mtte_checker.sv -----
// Watches the key, config and cell channels, predicts each cell write and compares.
`timescale 1ns / 1ps

module mtte_scoreboard (
  input  logic clk,
  input  logic rst,
  mtte_in_if   key_in,
  mtte_out_if  cell_out,
  mtte_cfg_if  cfg,
  output int   mismatches,
  output int   pending,
  output int   keys_seen,
  output int   ticks_seen,
  output int   writes_checked
);
  import mtte_pkg::*;

  typedef struct {
    char_t            char_code;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             replaced;
    logic [TAP_W-1:0] tap_index;
  } cell_write_t;

  cell_write_t expected_writes [$];

  // Predicted block state
  logic [PERIOD_W-1:0] period;
  int unsigned         tick_count;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic                prev_valid;
  logic [KEY_W-1:0]    prev_key;
  logic [TAP_W-1:0]    tap;

  // Letters printed on each key, row * 4 + column
  function automatic string key_letters(input logic [KEY_W-1:0] key);
    case (key)
      4'd0:    return "1";
      4'd1:    return "2abc";
      4'd2:    return "3def";
      4'd3:    return "U";
      4'd4:    return "4ghi";
      4'd5:    return "5jkl";
      4'd6:    return "6mno";
      4'd7:    return "D";
      4'd8:    return "7pqrs";
      4'd9:    return "8tuv";
      4'd10:   return "9wxyz";
      4'd11:   return "M";
      4'd12:   return "N";
      4'd13:   return "0";
      4'd14:   return "S";
      default: return "E";
    endcase
  endfunction

  // Advance the tick counter, then turn a key press into the expected cell write
  task automatic predict_cell_write(input logic op, input logic [1:0] kr,
                                    input logic [1:0] kc);
    int unsigned      span;
    int unsigned      nxt;
    int unsigned      n;
    logic [KEY_W-1:0] key;
    string            letters;
    logic             again;
    cell_write_t      w;
    span = (period == '0) ? 1 : int'(period);
    nxt  = tick_count + 1;
    if (nxt >= span) begin
      nxt        = nxt % span;
      prev_valid = 1'b0;
    end
    tick_count = nxt;
    if (op == OP_TICK) begin
      ticks_seen++;
      return;
    end
    keys_seen++;
    key     = {kr, kc};
    letters = key_letters(key);
    n       = letters.len();
    if (n > TAP_OPTIONS) n = TAP_OPTIONS;
    if (n == 0) n = 1;
    again = prev_valid && (prev_key == key);
    if (again) begin
      tap = TAP_W'((int'(tap) + 1) % n);
      // repeated tap steps back onto the cell written last
      if (cur_col == '0) begin
        cur_col = LAST_COL;
        cur_row = (cur_row == '0) ? LAST_ROW : cur_row - 1'b1;
      end else begin
        cur_col = cur_col - 1'b1;
      end
    end else begin
      tap = '0;
    end
    w.char_code = char_t'(letters[tap]);
    w.cell_row  = cur_row;
    w.cell_col  = cur_col;
    w.replaced  = again;
    w.tap_index = tap;
    expected_writes.push_back(w);
    // cursor moves on, wrapping over rows
    if (cur_col == LAST_COL) begin
      cur_col = '0;
      cur_row = (cur_row == LAST_ROW) ? '0 : cur_row + 1'b1;
    end else begin
      cur_col = cur_col + 1'b1;
    end
    prev_key   = key;
    prev_valid = 1'b1;
  endtask

  // Compare one accepted cell write against the oldest expectation
  task automatic check_cell_write();
    cell_write_t w;
    if (expected_writes.size() == 0) begin
      mismatches <= mismatches + 1;
      if (mismatches < 10)
        $display("unexpected cell write: char %h row %0d col %0d repl %0b tap %0d",
                 cell_out.char_code, cell_out.cell_row, cell_out.cell_col,
                 cell_out.replaced, cell_out.tap_index);
      return;
    end
    w = expected_writes.pop_front();
    writes_checked++;
    if (w.char_code !== cell_out.char_code || w.cell_row !== cell_out.cell_row ||
        w.cell_col !== cell_out.cell_col || w.replaced !== cell_out.replaced ||
        w.tap_index !== cell_out.tap_index) begin
      mismatches <= mismatches + 1;
      if (mismatches < 10)
        $display("cell write mismatch: exp char %h row %0d col %0d repl %0b tap %0d, ",
                 w.char_code, w.cell_row, w.cell_col, w.replaced, w.tap_index,
                 "got char %h row %0d col %0d repl %0b tap %0d",
                 cell_out.char_code, cell_out.cell_row, cell_out.cell_col,
                 cell_out.replaced, cell_out.tap_index);
    end
  endtask

  initial begin
    mismatches     = 0;
    pending        = 0;
    keys_seen      = 0;
    ticks_seen     = 0;
    writes_checked = 0;
  end

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      period     = FORGET_PERIOD_RESET;
      tick_count = 0;
      cur_col    = '0;
      cur_row    = '0;
      prev_valid = 1'b0;
      prev_key   = '0;
      tap        = '0;
      expected_writes.delete();
    end else begin
      if (cell_out.valid && cell_out.ready) check_cell_write();
      if (cfg.valid && cfg.ready) period = cfg.data;
      if (key_in.valid && key_in.ready)
        predict_cell_write(key_in.op, key_in.key_row, key_in.key_col);
    end
    pending <= expected_writes.size();
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top: clock, reset, key/tick and period stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb;
  import mtte_pkg::*;

  localparam int SETTLE_CYCLES   = 4;
  localparam int ITEMS_PER_PHASE = 296;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;

  int src_idle_pct  = 26;
  int sink_idle_pct = 68;
  int mismatches, pending, keys_seen, ticks_seen, writes_checked;
  int period_writes = 0;
  logic [1:0] last_row = '0;
  logic [1:0] last_col = '0;

  logic [PERIOD_W-1:0] phase_periods [6] = '{16'd1, 16'd0, 16'd65535, 16'd4, 16'd9, 16'd23};

  mtte_in_if  key_bus ();
  mtte_out_if cell_bus ();
  mtte_cfg_if cfg_bus ();

  assign cell_bus.ready = sink_ready;

  multi_tap_text_entry uut (
    .clk      (clk),
    .rst      (rst),
    .key_in   (key_bus),
    .cell_out (cell_bus),
    .cfg      (cfg_bus)
  );

  mtte_scoreboard u_scoreboard (
    .clk            (clk),
    .rst            (rst),
    .key_in         (key_bus),
    .cell_out       (cell_bus),
    .cfg            (cfg_bus),
    .mismatches     (mismatches),
    .pending        (pending),
    .keys_seen      (keys_seen),
    .ticks_seen     (ticks_seen),
    .writes_checked (writes_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Present one item after a random gap and hold it until taken
  task automatic send_item(input logic op, input logic [1:0] kr, input logic [1:0] kc);
    while ($urandom_range(99) < src_idle_pct) begin
      key_bus.valid <= 1'b0;
      @(posedge clk);
    end
    key_bus.valid   <= 1'b1;
    key_bus.op      <= op;
    key_bus.key_row <= kr;
    key_bus.key_col <= kc;
    @(posedge clk);
    while (!key_bus.ready) @(posedge clk);
    if (op == OP_KEY) begin
      last_row = kr;
      last_col = kc;
    end
  endtask

  // Mostly key presses with runs of repeats, some bare ticks
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15)
      send_item(OP_TICK, 2'($urandom), 2'($urandom));
    else if (pick < 60)
      send_item(OP_KEY, last_row, last_col);
    else
      send_item(OP_KEY, 2'($urandom), 2'($urandom));
  endtask

  // Wait until every expected cell write is out and the block has settled
  task automatic wait_drained();
    key_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    period_writes++;
  endtask

  initial begin
    key_bus.valid   <= 1'b0;
    key_bus.op      <= OP_TICK;
    key_bus.key_row <= '0;
    key_bus.key_col <= '0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.data    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: every key once, fills row 0 so the cursor wraps to row 1
    for (int k = 0; k < KEY_COUNT; k++) begin
      send_item(OP_KEY, 2'(k >> 2), 2'(k & 3));
    end
    // single-letter repeat at column 0 steps back to the previous row
    send_item(OP_KEY, 2'd3, 2'd3);
    // five-letter key tapped past its last letter
    repeat (6) send_item(OP_KEY, 2'd2, 2'd2);
    send_item(OP_TICK, 2'd3, 2'd3);

    // Random phases over several periods and idle patterns
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        src_idle_pct  = 68;
        sink_idle_pct = 26;
      end else if (p == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_period(phase_periods[p]);
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d key presses and %0d ticks, %0d cell writes checked",
             keys_seen, ticks_seen, writes_checked);
    $display("over %0d period writes, including 0, 1 and 65535, under three idle patterns",
             period_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
